// ===== src/lcu_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcu_pkg
// Shared widths, request/response types and pipeline control for the
// Lagrangian cell conserved update core.
// ---------------------------------------------------------------------------
package lcu_pkg;

    localparam int DATA_W      = 32;            // signed Q16.16 values
    localparam int FRAC_W      = 16;
    localparam int UNS_W       = DATA_W - 1;    // unsigned Q15.16 values
    localparam int PIPE_STAGES = 5;

    localparam logic [UNS_W-1:0] TIME_STEP_RESET = UNS_W'(655);

    typedef struct packed {
        logic signed [DATA_W-1:0] cell_energy;
        logic signed [DATA_W-1:0] cell_momentum_x;
        logic signed [DATA_W-1:0] cell_volume;
        logic        [UNS_W-1:0]  mass_step_ratio;
        logic signed [DATA_W-1:0] left_edge;
        logic signed [DATA_W-1:0] right_edge;
        logic signed [DATA_W-1:0] pressure_left;
        logic signed [DATA_W-1:0] pressure_right;
        logic signed [DATA_W-1:0] velocity_left;
        logic signed [DATA_W-1:0] velocity_right;
    } t_cell_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] new_energy;
        logic signed [DATA_W-1:0] new_momentum_x;
        logic signed [DATA_W-1:0] new_volume;
        logic signed [DATA_W-1:0] new_left_edge;
        logic signed [DATA_W-1:0] new_right_edge;
        logic signed [DATA_W-1:0] new_center;
        logic                     saturated;
    } t_cell_rsp;

    typedef struct packed {
        logic [PIPE_STAGES-1:0] load;   // stage register captures this cycle
        logic [PIPE_STAGES-1:0] valid;  // stage register holds a request
    } t_pipe_ctl;

endpackage

// ===== src/lcu_pipe_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcu_pipe_ctrl
// Valid bits and per-stage ready chain; a stage loads whenever it is empty
// or the stage after it moves, so bubbles collapse under output stall.
// ---------------------------------------------------------------------------
module lcu_pipe_ctrl
    import lcu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_ready,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_pipe_ctl o_ctl
);

    logic [PIPE_STAGES-1:0] r_valid;
    logic [PIPE_STAGES-1:0] n_valid;
    logic [PIPE_STAGES-1:0] valid_in;
    logic [PIPE_STAGES:0]   stage_ready;

    always_comb begin
        stage_ready[PIPE_STAGES] = i_out_ready;
        for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
            stage_ready[k] = !r_valid[k] || stage_ready[k+1];
        end
    end

    always_comb begin
        valid_in = {r_valid[PIPE_STAGES-2:0], i_in_valid};
        for (int k = 0; k < PIPE_STAGES; k++) begin
            n_valid[k]    = stage_ready[k] ? valid_in[k] : r_valid[k];
            o_ctl.load[k] = stage_ready[k] && valid_in[k];
        end
        o_ctl.valid = r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = stage_ready[0];
    assign o_out_valid = r_valid[PIPE_STAGES-1];

endmodule

// ===== src/lcu_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcu_datapath
// Five register stages: products, differences and rounding, split energy
// scaling, accumulation and edge clipping, final clipping and center.
// ---------------------------------------------------------------------------
module lcu_datapath
    import lcu_pkg::*;
(
    input  logic             i_clk,
    input  t_pipe_ctl        i_ctl,
    input  logic [UNS_W-1:0] i_time_step,
    input  t_cell_req        i_req,
    output t_cell_rsp        o_rsp
);

    localparam int PROD_W = 2 * DATA_W;         // full Q32.32 product
    localparam int RND_W  = PROD_W - FRAC_W;    // product rounded to Q32.16
    localparam int SUM_W  = RND_W + 1;
    localparam int WORK_W = PROD_W + 1;         // exact pressure-velocity work
    localparam int DIFF_W = DATA_W + 1;
    localparam int HI_W   = WORK_W - DATA_W;

    function automatic logic signed [RND_W-1:0] round_q(
        input logic signed [PROD_W-1:0] x
    );
        logic signed [PROD_W-1:0] t;
        t = x + (PROD_W'(1) << (FRAC_W - 1));
        return RND_W'(t >>> FRAC_W);
    endfunction

    // {clipped, value}
    function automatic logic [DATA_W:0] clip_q(input logic signed [WORK_W-1:0] x);
        logic [WORK_W-DATA_W:0] top;
        top = x[WORK_W-1:DATA_W-1];
        if (&top || ~|top) begin
            return {1'b0, x[DATA_W-1:0]};
        end else if (x[WORK_W-1]) begin
            return {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    // ---- stage 1: interface products, differences ----
    logic signed [DATA_W-1:0] s0_dt;
    logic signed [DATA_W-1:0] r1_e, r1_sx, r1_v, r1_xl, r1_xr;
    logic        [UNS_W-1:0]  r1_ratio;
    logic signed [DIFF_W-1:0] r1_dv, r1_dp;
    logic signed [PROD_W-1:0] r1_pvr, r1_pvl, r1_ldt, r1_rdt;

    assign s0_dt = $signed({1'b0, i_time_step});

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r1_e     <= i_req.cell_energy;
            r1_sx    <= i_req.cell_momentum_x;
            r1_v     <= i_req.cell_volume;
            r1_ratio <= i_req.mass_step_ratio;
            r1_xl    <= i_req.left_edge;
            r1_xr    <= i_req.right_edge;
            r1_dv    <= DIFF_W'(i_req.velocity_right) - DIFF_W'(i_req.velocity_left);
            r1_dp    <= DIFF_W'(i_req.pressure_right) - DIFF_W'(i_req.pressure_left);
            r1_pvr   <= i_req.pressure_right * i_req.velocity_right;
            r1_pvl   <= i_req.pressure_left * i_req.velocity_left;
            r1_ldt   <= i_req.velocity_left * s0_dt;
            r1_rdt   <= i_req.velocity_right * s0_dt;
        end
    end

    // ---- stage 2: work difference, ratio products, edge rounding ----
    logic signed [DATA_W-1:0] s1_ratio;
    logic signed [DATA_W-1:0] r2_e, r2_sx, r2_v, r2_xl, r2_xr;
    logic        [UNS_W-1:0]  r2_ratio;
    logic signed [WORK_W-1:0] r2_work;
    logic signed [PROD_W-1:0] r2_mv, r2_mp;
    logic signed [RND_W-1:0]  r2_ldt, r2_rdt;

    assign s1_ratio = $signed({1'b0, r1_ratio});

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r2_e     <= r1_e;
            r2_sx    <= r1_sx;
            r2_v     <= r1_v;
            r2_xl    <= r1_xl;
            r2_xr    <= r1_xr;
            r2_ratio <= r1_ratio;
            r2_work  <= WORK_W'(r1_pvr) - WORK_W'(r1_pvl);
            r2_mv    <= s1_ratio * r1_dv;
            r2_mp    <= s1_ratio * r1_dp;
            r2_ldt   <= round_q(r1_ldt);
            r2_rdt   <= round_q(r1_rdt);
        end
    end

    // ---- stage 3: work * ratio as high and low partial products ----
    logic signed [DATA_W-1:0] s2_ratio;
    logic signed [HI_W-1:0]   s2_wh;
    logic        [DATA_W-1:0] s2_wl;
    logic signed [DATA_W-1:0] r3_e, r3_sx, r3_v;
    logic signed [PROD_W-1:0] r3_whd;
    logic        [PROD_W-2:0] r3_wld;
    logic signed [RND_W-1:0]  r3_rv, r3_rp;
    logic signed [SUM_W-1:0]  r3_nl, r3_nr;

    assign s2_ratio = $signed({1'b0, r2_ratio});
    assign s2_wh    = $signed(r2_work[WORK_W-1:DATA_W]);
    assign s2_wl    = r2_work[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r3_e   <= r2_e;
            r3_sx  <= r2_sx;
            r3_v   <= r2_v;
            r3_whd <= s2_wh * s2_ratio;
            r3_wld <= s2_wl * r2_ratio;
            r3_rv  <= round_q(r2_mv);
            r3_rp  <= round_q(r2_mp);
            r3_nl  <= SUM_W'(r2_xl) + SUM_W'(r2_ldt);
            r3_nr  <= SUM_W'(r2_xr) + SUM_W'(r2_rdt);
        end
    end

    // ---- stage 4: energy decrement, volume/momentum sums, edge clip ----
    logic        [PROD_W-1:0] s3_wsum;
    logic        [DATA_W-1:0] s3_whi;
    logic        [DATA_W:0]   s3_cl, s3_cr;
    logic signed [DATA_W-1:0] r4_e, r4_nl, r4_nr;
    logic signed [PROD_W-1:0] r4_q;
    logic signed [SUM_W-1:0]  r4_nv, r4_nm;
    logic                     r4_sat;

    assign s3_wsum = PROD_W'(r3_wld) + (PROD_W'(1) << (DATA_W - 1));
    assign s3_whi  = s3_wsum[PROD_W-1:DATA_W];
    assign s3_cl   = clip_q(WORK_W'(r3_nl));
    assign s3_cr   = clip_q(WORK_W'(r3_nr));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r4_e   <= r3_e;
            r4_q   <= r3_whd + $signed({1'b0, s3_whi});
            r4_nv  <= SUM_W'(r3_v) + SUM_W'(r3_rv);
            r4_nm  <= SUM_W'(r3_sx) - SUM_W'(r3_rp);
            r4_nl  <= s3_cl[DATA_W-1:0];
            r4_nr  <= s3_cr[DATA_W-1:0];
            r4_sat <= s3_cl[DATA_W] | s3_cr[DATA_W];
        end
    end

    // ---- stage 5: final clipping and cell center ----
    logic        [DATA_W:0]   s4_ce, s4_cv, s4_cm;
    logic signed [DIFF_W-1:0] s4_csum;
    t_cell_rsp                r5_rsp;

    assign s4_ce   = clip_q(WORK_W'(r4_e) - WORK_W'(r4_q));
    assign s4_cv   = clip_q(WORK_W'(r4_nv));
    assign s4_cm   = clip_q(WORK_W'(r4_nm));
    assign s4_csum = DIFF_W'(r4_nl) + DIFF_W'(r4_nr);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r5_rsp.new_energy     <= s4_ce[DATA_W-1:0];
            r5_rsp.new_momentum_x <= s4_cm[DATA_W-1:0];
            r5_rsp.new_volume     <= s4_cv[DATA_W-1:0];
            r5_rsp.new_left_edge  <= r4_nl;
            r5_rsp.new_right_edge <= r4_nr;
            r5_rsp.new_center     <= s4_csum[DIFF_W-1:1];
            r5_rsp.saturated      <= r4_sat | s4_ce[DATA_W] | s4_cv[DATA_W]
                                     | s4_cm[DATA_W];
        end
    end

    assign o_rsp = r5_rsp;

endmodule

// ===== src/lagrangian_cell_conserved_update_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lagrangian_cell_conserved_update_core
// One-dimensional Lagrangian cell update: new volume, momentum and energy
// from the interface pressures and velocities, and moved cell edges/center.
// ---------------------------------------------------------------------------
// Pipeline: five register stages, set by the split 65x31 energy product.
// Throughput: one request per cycle unless the output stalls; a stage takes
//   a new request when it is empty or its successor moves, so input is still
//   accepted while a result waits at the output as long as a bubble remains.
// Reset: synchronous, active low; clears all stage valid bits and loads
//   time_step with 655 (0.01 in Q15.16). Datapath registers are not reset.
// ---------------------------------------------------------------------------
module lagrangian_cell_conserved_update_core
    import lcu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // time step configuration, unsigned Q15.16
    input  logic             i_cfg_wr_en,
    input  logic [UNS_W-1:0] i_cfg_wr_data,
    // cell request
    input  logic             i_valid,
    output logic             o_ready,
    input  t_cell_req        i_req,
    // update result
    output logic             o_valid,
    input  logic             i_ready,
    output t_cell_rsp        o_rsp
);

    // Time step register. The user must keep it written only while no request
    // is in flight, so stage 1 samples it directly; the block does not enforce it.
    logic [UNS_W-1:0] r_time_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TIME_STEP_RESET;
        end else if (i_cfg_wr_en) begin
            r_time_step <= i_cfg_wr_data;
        end
    end

    // Handshake and stage enables
    t_pipe_ctl pipe_ctl;

    lcu_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_ready (i_ready),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_ctl       (pipe_ctl)
    );

    // Arithmetic:
    //   stage 1  p*v products, edge velocity * dt, velocity/pressure deltas
    //   stage 2  exact work difference, ratio * deltas, edge rounding
    //   stage 3  work * ratio in high/low halves, round, raw edge sums
    //   stage 4  energy decrement assembled, volume/momentum sums, edge clip
    //   stage 5  energy/volume/momentum clip, center = floor(sum / 2)
    lcu_datapath u_datapath (
        .i_clk       (i_clk),
        .i_ctl       (pipe_ctl),
        .i_time_step (r_time_step),
        .i_req       (i_req),
        .o_rsp       (o_rsp)
    );

    // ---- assertions ----

    // Reset always restores the default time step
    a_ts_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_time_step == TIME_STEP_RESET)
        else $error("time step not restored by reset");

    // Empty pipeline must accept
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pipe_ctl.valid == '0 |-> o_ready)
        else $error("empty pipeline not ready");

    // Center lies between the two moved edges
    a_center_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            (o_rsp.new_center >= o_rsp.new_left_edge
             || o_rsp.new_center >= o_rsp.new_right_edge)
            && (o_rsp.new_center <= o_rsp.new_left_edge
             || o_rsp.new_center <= o_rsp.new_right_edge))
        else $error("cell center outside its edges");

endmodule
